@@ rtl/core/tts_pkg.sv @@
// Package: sizes, memory port struct and saturation helper for the tridiagonal solver.
`default_nettype none
package tts_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int PROD_W     = DATA_W + CNT_W + 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } store_wr_t;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1])
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      sat_add = s[DATA_W-1:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/tts_if.sv @@
// Channel interfaces for solver request and response items.
`default_nettype none
interface tts_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] rhs_value;
  logic        last;
  logic [9:0]  read_index;
  modport source (output valid, operation, rhs_value, last, read_index, input ready);
  modport sink (input valid, operation, rhs_value, last, read_index, output ready);
endinterface

interface tts_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] solution;
  logic [10:0] point_count;
  logic        error;
  modport source (output valid, kind, solution, point_count, error, input ready);
  modport sink (input valid, kind, solution, point_count, error, output ready);
endinterface
`default_nettype wire

@@ rtl/core/toeplitz_tridiagonal_solver_core.sv @@
// Top level: load/read handling and the forward and backward sweep sequencer.
// Read item: an error item is registered on acceptance; a valid read is answered
// from S_RD. A load without last gives no item. Solve: per interior point a read,
// a multiply and a PROD_W-step division in each sweep; the shared divider sets the pace.
// One item at a time; ready is low during a read or a solve.
// Synchronous reset clears count, solved flag and control; the store is not cleared.
`default_nettype none
module toeplitz_tridiagonal_solver_core (
  input  wire logic clk,
  input  wire logic rst,
  tts_req_if.sink   req,
  tts_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_ZERO, S_FW_RD, S_FW_MUL, S_FW_GO, S_FW_WAIT,
    S_BK_Z, S_BK_RD, S_BK_MUL, S_BK_GO, S_BK_WAIT, S_BK_END, S_FIN
  } state_t;

  state_t                                  state;
  logic [tts_pkg::CNT_W-1:0]               cnt;
  logic [tts_pkg::CNT_W-1:0]               n;
  logic                                    solved;
  logic [tts_pkg::ADDR_W-1:0]              idx;
  logic signed [tts_pkg::DATA_W-1:0]       carry;
  logic signed [tts_pkg::PROD_W-1:0]       prod;
  logic [tts_pkg::CNT_W-1:0]               den;
  logic                                    out_valid;
  logic                                    out_kind;
  logic signed [tts_pkg::DATA_W-1:0]       out_sol;
  logic [tts_pkg::CNT_W-1:0]               out_cnt;
  logic                                    out_err;

  tts_pkg::store_wr_t                      wr;
  logic [tts_pkg::ADDR_W-1:0]              raddr;
  logic signed [tts_pkg::DATA_W-1:0]       rdata;
  logic                                    dv_done;
  logic signed [tts_pkg::DATA_W-1:0]       dv_q;

  logic                                    acc;
  logic [tts_pkg::CNT_W-1:0]               cnt_eff;
  logic                                    full;
  logic [tts_pkg::CNT_W-1:0]               n_new;
  logic [tts_pkg::CNT_W-1:0]               idx_w;
  logic signed [tts_pkg::DATA_W-1:0]       fw_sum;
  logic signed [tts_pkg::DATA_W-1:0]       bk_sum;

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign cnt_eff   = solved ? '0 : cnt;
  assign full      = (cnt_eff == tts_pkg::CNT_W'(tts_pkg::MAX_POINTS));
  assign n_new     = full ? cnt_eff : cnt_eff + 1'b1;
  assign idx_w     = {1'b0, idx};
  assign fw_sum    = tts_pkg::sat_add(rdata, dv_q);
  assign bk_sum    = tts_pkg::sat_add(rdata, carry);
  assign raddr     = (state == S_IDLE) ? req.read_index[tts_pkg::ADDR_W-1:0] : idx;

  always_comb begin
    wr = '{en: 1'b0, addr: idx, data: '0};
    unique case (state)
      S_IDLE: begin
        wr.en   = acc && (req.operation == tts_pkg::OP_LOAD) && !full;
        wr.addr = cnt_eff[tts_pkg::ADDR_W-1:0];
        wr.data = req.rhs_value;
      end
      S_ZERO:    wr.en = 1'b1;
      S_FW_WAIT: begin
        wr.en   = dv_done;
        wr.data = fw_sum;
      end
      S_BK_Z:    wr.en = 1'b1;
      S_BK_WAIT: begin
        wr.en   = dv_done;
        wr.data = dv_q;
      end
      S_BK_END: begin
        wr.en   = 1'b1;
        wr.addr = '0;
      end
      default: ;
    endcase
  end

  tts_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  tts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    ((state == S_FW_GO) || (state == S_BK_GO)),
    .dividend (prod),
    .divisor  (den),
    .done     (dv_done),
    .quotient (dv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      solved    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc && req.operation == tts_pkg::OP_LOAD) begin
            cnt    <= n_new;
            solved <= 1'b0;
            if (req.last) begin
              n   <= n_new;
              idx <= '0;
              if (n_new <= tts_pkg::CNT_W'(2)) begin
                state <= S_ZERO;
              end else begin
                idx   <= tts_pkg::ADDR_W'(1);
                carry <= '0;
                state <= S_FW_RD;
              end
            end
          end else if (acc) begin
            if (!solved || {1'b0, req.read_index} >= cnt) begin
              out_valid <= 1'b1;
              out_kind  <= tts_pkg::KIND_DATA;
              out_sol   <= '0;
              out_cnt   <= '0;
              out_err   <= 1'b1;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          out_valid <= 1'b1;
          out_kind  <= tts_pkg::KIND_DATA;
          out_sol   <= rdata;
          out_cnt   <= '0;
          out_err   <= 1'b0;
          state     <= S_IDLE;
        end
        S_ZERO: begin
          if (idx_w + 1'b1 >= n) state <= S_FIN;
          else idx <= idx + 1'b1;
        end
        S_FW_RD:  state <= S_FW_MUL;
        S_FW_MUL: begin
          prod  <= tts_pkg::PROD_W'(carry * $signed({1'b0, idx_w - 1'b1}));
          den   <= idx_w;
          state <= S_FW_GO;
        end
        S_FW_GO:  state <= S_FW_WAIT;
        S_FW_WAIT: begin
          if (dv_done) begin
            carry <= fw_sum;
            if (idx_w == n - tts_pkg::CNT_W'(2)) begin
              idx   <= tts_pkg::ADDR_W'(n - 1'b1);
              state <= S_BK_Z;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FW_RD;
            end
          end
        end
        S_BK_Z: begin
          carry <= '0;
          idx   <= idx - 1'b1;
          state <= S_BK_RD;
        end
        S_BK_RD:  state <= S_BK_MUL;
        S_BK_MUL: begin
          prod  <= tts_pkg::PROD_W'(bk_sum * $signed({1'b0, idx_w}));
          den   <= idx_w + 1'b1;
          state <= S_BK_GO;
        end
        S_BK_GO:  state <= S_BK_WAIT;
        S_BK_WAIT: begin
          if (dv_done) begin
            carry <= dv_q;
            if (idx == tts_pkg::ADDR_W'(1)) begin
              state <= S_BK_END;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_BK_RD;
            end
          end
        end
        S_BK_END: state <= S_FIN;
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_kind  <= tts_pkg::KIND_DONE;
            out_sol   <= '0;
            out_cnt   <= n;
            out_err   <= 1'b0;
            solved    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.kind        = out_kind;
  assign rsp.solution    = out_sol;
  assign rsp.point_count = out_cnt;
  assign rsp.error       = out_err;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == S_FW_WAIT || state == S_BK_WAIT))
    else $error("divider finished outside a sweep wait");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.error) |-> (rsp.solution == '0 && rsp.kind == tts_pkg::KIND_DATA))
    else $error("error item carries data");
  a_done_solved: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.kind == tts_pkg::KIND_DONE) |-> solved)
    else $error("solve finished item without solved flag");
endmodule
`default_nettype wire

@@ rtl/core/tts_store.sv @@
// Work store: single write port, one registered read port.
`default_nettype none
module tts_store (
  input  wire logic                                   clk,
  input  wire tts_pkg::store_wr_t                     wr,
  input  wire logic [tts_pkg::ADDR_W-1:0]             raddr,
  output logic signed [tts_pkg::DATA_W-1:0]           rdata
);
  logic signed [tts_pkg::DATA_W-1:0] mem [tts_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/tts_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module tts_divider (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [tts_pkg::PROD_W-1:0]      dividend,
  input  wire logic [tts_pkg::CNT_W-1:0]              divisor,
  output logic                                        done,
  output logic signed [tts_pkg::DATA_W-1:0]           quotient
);
  localparam int STEP_W = $clog2(tts_pkg::PROD_W + 1);

  logic                          busy;
  logic                          neg;
  logic [STEP_W-1:0]             step;
  logic [tts_pkg::CNT_W-1:0]     den;
  logic [tts_pkg::CNT_W-1:0]     rem;
  logic [tts_pkg::PROD_W-1:0]    quo;
  logic [tts_pkg::CNT_W:0]       trial;
  logic                          qbit;
  logic [tts_pkg::PROD_W-1:0]    quo_next;
  logic [tts_pkg::PROD_W-1:0]    res;

  always_comb begin
    trial    = {rem, quo[tts_pkg::PROD_W-1]};
    qbit     = (trial >= {1'b0, den});
    quo_next = {quo[tts_pkg::PROD_W-2:0], qbit};
    res      = neg ? (~quo_next + 1'b1) : quo_next;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      neg  <= dividend[tts_pkg::PROD_W-1];
      quo  <= dividend[tts_pkg::PROD_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
      den  <= divisor;
      step <= STEP_W'(tts_pkg::PROD_W - 1);
    end else if (busy) begin
      rem <= qbit ? tts_pkg::CNT_W'(trial - {1'b0, den}) : trial[tts_pkg::CNT_W-1:0];
      quo <= quo_next;
      if (step == '0) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= res[tts_pkg::DATA_W-1:0];
      end else begin
        step <= step - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire
